// ----- rtl/core/lpr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
`default_nettype none

package lpr_pkg;

    // Default sizes of the frame set and of a stored page number.
    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // Field widths on the stream and configuration ports.
    localparam int PAGE_W      = 16;
    localparam int FIDX_W      = 3;
    localparam int TOTAL_W     = 32;
    localparam int CFG_W       = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = 1 + FIDX_W + 1 + PAGE_W + 2 * TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

    // Control bits of the search wave that travels along the frame cells.
    typedef struct packed {
        logic tok;
        logic found;
        logic vhave;
    } scan_flags_t;

    // Control bits of the update broadcast to every frame cell.
    typedef struct packed {
        logic apply;
        logic hit;
    } upd_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpr_cell.sv -----
// One frame cell: holds a page, its valid bit and recency rank, and passes the search wave on.
`default_nettype none

module lpr_cell #(
    parameter int NUM_FRAMES = lpr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
    localparam int CNT_W     = $clog2(NUM_FRAMES + 1)
) (
    input  wire                        clk,
    input  wire                        rst_n,
    // Broadcast lookup key and active frame count.
    input  wire  [PAGE_BITS-1:0]       pg,
    input  wire  [CNT_W-1:0]           n_act,
    // Search wave from the previous cell.
    input  wire lpr_pkg::scan_flags_t  in_flags,
    input  wire  [IDX_W-1:0]           in_fidx,
    input  wire  [IDX_W-1:0]           in_frank,
    input  wire  [IDX_W-1:0]           in_vidx,
    input  wire  [IDX_W-1:0]           in_vrank,
    input  wire  [PAGE_BITS-1:0]       in_vpage,
    // Search wave to the next cell.
    output lpr_pkg::scan_flags_t       out_flags,
    output logic [IDX_W-1:0]           out_fidx,
    output logic [IDX_W-1:0]           out_frank,
    output logic [IDX_W-1:0]           out_vidx,
    output logic [IDX_W-1:0]           out_vrank,
    output logic [PAGE_BITS-1:0]       out_vpage,
    // Update broadcast.
    input  wire lpr_pkg::upd_ctrl_t    upd,
    input  wire  [IDX_W-1:0]           upd_slot,
    input  wire  [IDX_W-1:0]           upd_old_rank,
    input  wire  [PAGE_BITS-1:0]       upd_page
);
    import lpr_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(NUM_FRAMES - 1);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 valid_reg, valid_next;
    logic [IDX_W-1:0]     rank_reg, rank_next;

    scan_flags_t          flags_reg, flags_next;
    logic [IDX_W-1:0]     fidx_reg, fidx_next;
    logic [IDX_W-1:0]     frank_reg, frank_next;
    logic [IDX_W-1:0]     vidx_reg, vidx_next;
    logic [IDX_W-1:0]     vrank_reg, vrank_next;
    logic [PAGE_BITS-1:0] vpage_reg, vpage_next;

    logic                 live;
    logic                 match;
    logic                 better;
    logic                 is_slot;
    logic [IDX_W-1:0]     rank_aged;

    assign live      = (CNT_W'(CELL_IDX) < n_act) && valid_reg;
    assign match     = live && (page_reg == pg);
    assign better    = live && (!in_flags.vhave || (rank_reg > in_vrank));
    assign is_slot   = (upd_slot == MY_IDX);
    assign rank_aged = (rank_reg < RANK_TOP) ? rank_reg + IDX_W'(1) : rank_reg;

    // Search step: first matching frame, and the oldest frame with the lowest index on ties.
    always_comb
    begin
        flags_next.tok   = in_flags.tok;
        flags_next.found = in_flags.found || match;
        flags_next.vhave = in_flags.vhave || live;
        fidx_next        = in_fidx;
        frank_next       = in_frank;
        vidx_next        = in_vidx;
        vrank_next       = in_vrank;
        vpage_next       = in_vpage;
        if (!in_flags.found && match)
        begin
            fidx_next  = MY_IDX;
            frank_next = rank_reg;
        end
        if (better)
        begin
            vidx_next  = MY_IDX;
            vrank_next = rank_reg;
            vpage_next = page_reg;
        end
    end

    // Update step: the chosen frame becomes most recent, others age as the access demands.
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.apply)
        begin
            if (upd.hit)
            begin
                if (is_slot)
                begin
                    rank_next = '0;
                end
                else if (live && (rank_reg < upd_old_rank))
                begin
                    rank_next = rank_aged;
                end
            end
            else
            begin
                if (is_slot)
                begin
                    page_next  = upd_page;
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
                else if (live)
                begin
                    rank_next = rank_aged;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        fidx_reg  <= fidx_next;
        frank_reg <= frank_next;
        vidx_reg  <= vidx_next;
        vrank_reg <= vrank_next;
        vpage_reg <= vpage_next;
    end

    assign out_flags = flags_reg;
    assign out_fidx  = fidx_reg;
    assign out_frank = frank_reg;
    assign out_vidx  = vidx_reg;
    assign out_vrank = vrank_reg;
    assign out_vpage = vpage_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lru_page_replacement.sv -----
// Top level of the LRU page replacement block: control, totals and the row of frame cells.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+--------------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tdata: page
//  m_      | out       | m_tvalid / m_tready | m_tdata: hit, frame_index, evicted_valid,
//          |           |                     |   evicted_page, hit_total, fault_total
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data: frames_in_use
//
// One page reference at a time. The lookup wave crosses one frame cell per cycle, and a
// new page is taken only once the result of the last one is in the output register.
// The result leaves through that register; while it still waits for m_tready, a further
// decision is held in the block, which then takes no new page. Reset clears all valid bits,
// ranks, the fill count and the totals at once, and frames_in_use returns to 8.
`default_nettype none

module lru_page_replacement #(
    parameter int NUM_FRAMES = lpr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [lpr_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] page
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [0] hit, [3:1] frame_index, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] hit_total, [84:53] fault_total, [87:85] zero
    output logic [lpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [lpr_pkg::CFG_W-1:0]         cfg_data
);
    import lpr_pkg::*;

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PEND
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       fiu_reg, fiu_next;
    logic [PAGE_BITS-1:0]   pg_reg, pg_next;
    logic                   start_reg, start_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [TOTAL_W-1:0]     hits_reg, hits_next;
    logic [TOTAL_W-1:0]     faults_reg, faults_next;
    upd_ctrl_t              upd_reg, upd_next;
    logic [IDX_W-1:0]       upd_old_reg, upd_old_next;
    logic                   pend_hit_reg, pend_hit_next;
    logic [IDX_W-1:0]       pend_slot_reg, pend_slot_next;
    logic                   pend_ev_reg, pend_ev_next;
    logic [PAGE_BITS-1:0]   pend_evpage_reg, pend_evpage_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CNT_W-1:0]       n_act;
    logic                   s_xfer;

    scan_flags_t            flags_w [NUM_FRAMES+1];
    logic [IDX_W-1:0]       fidx_w  [NUM_FRAMES+1];
    logic [IDX_W-1:0]       frank_w [NUM_FRAMES+1];
    logic [IDX_W-1:0]       vidx_w  [NUM_FRAMES+1];
    logic [IDX_W-1:0]       vrank_w [NUM_FRAMES+1];
    logic [PAGE_BITS-1:0]   vpage_w [NUM_FRAMES+1];

    scan_flags_t            scan_end;

    // An out-of-range register value is pulled into 1..NUM_FRAMES.
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (NW'(fiu_reg) > NW'(NUM_FRAMES))
        begin
            n_act = CNT_W'(NUM_FRAMES);
        end
        else
        begin
            n_act = CNT_W'(fiu_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Head of the cell row.
    assign flags_w[0] = '{tok: start_reg, found: 1'b0, vhave: 1'b0};
    assign fidx_w[0]  = '0;
    assign frank_w[0] = '0;
    assign vidx_w[0]  = '0;
    assign vrank_w[0] = '0;
    assign vpage_w[0] = '0;

    for (genvar k = 0; k < NUM_FRAMES; k++)
    begin : g_cell
        lpr_cell #(
            .NUM_FRAMES (NUM_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .CELL_IDX   (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .pg           (pg_reg),
            .n_act        (n_act),
            .in_flags     (flags_w[k]),
            .in_fidx      (fidx_w[k]),
            .in_frank     (frank_w[k]),
            .in_vidx      (vidx_w[k]),
            .in_vrank     (vrank_w[k]),
            .in_vpage     (vpage_w[k]),
            .out_flags    (flags_w[k+1]),
            .out_fidx     (fidx_w[k+1]),
            .out_frank    (frank_w[k+1]),
            .out_vidx     (vidx_w[k+1]),
            .out_vrank    (vrank_w[k+1]),
            .out_vpage    (vpage_w[k+1]),
            .upd          (upd_reg),
            .upd_slot     (pend_slot_reg),
            .upd_old_rank (upd_old_reg),
            .upd_page     (pg_reg)
        );
    end

    assign scan_end = flags_w[NUM_FRAMES];

    always_comb
    begin
        state_next       = state_reg;
        fiu_next         = fiu_reg;
        pg_next          = pg_reg;
        start_next       = 1'b0;
        fill_next        = fill_reg;
        hits_next        = hits_reg;
        faults_next      = faults_reg;
        upd_next         = '{apply: 1'b0, hit: 1'b0};
        upd_old_next     = upd_old_reg;
        pend_hit_next    = pend_hit_reg;
        pend_slot_next   = pend_slot_reg;
        pend_ev_next     = pend_ev_reg;
        pend_evpage_next = pend_evpage_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (cfg_valid)
        begin
            fiu_next = cfg_data;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    pg_next    = PAGE_BITS'(s_tdata);
                    start_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end.tok)
                begin
                    state_next       = ST_PEND;
                    upd_next.apply   = 1'b1;
                    upd_old_next     = frank_w[NUM_FRAMES];
                    pend_ev_next     = 1'b0;
                    pend_evpage_next = '0;
                    if (scan_end.found)
                    begin
                        upd_next.hit   = 1'b1;
                        pend_hit_next  = 1'b1;
                        pend_slot_next = fidx_w[NUM_FRAMES];
                        hits_next      = (hits_reg == '1) ? hits_reg : hits_reg + TOTAL_W'(1);
                    end
                    else
                    begin
                        pend_hit_next = 1'b0;
                        faults_next   = (faults_reg == '1) ? faults_reg
                                                           : faults_reg + TOTAL_W'(1);
                        if (fill_reg < n_act)
                        begin
                            pend_slot_next = IDX_W'(fill_reg);
                            fill_next      = fill_reg + CNT_W'(1);
                        end
                        else
                        begin
                            pend_slot_next = vidx_w[NUM_FRAMES];
                            pend_ev_next   = scan_end.vhave;
                            if (scan_end.vhave)
                            begin
                                pend_evpage_next = vpage_w[NUM_FRAMES];
                            end
                        end
                    end
                end
            end
            ST_PEND:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {OUT_PAD_W'(0), faults_reg, hits_reg,
                                      PAGE_W'(pend_evpage_reg), pend_ev_reg,
                                      FIDX_W'(pend_slot_reg), pend_hit_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fiu_reg       <= FRAMES_RESET;
            start_reg     <= 1'b0;
            fill_reg      <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
            upd_reg       <= '{apply: 1'b0, hit: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            start_reg     <= start_next;
            fill_reg      <= fill_next;
            hits_reg      <= hits_next;
            faults_reg    <= faults_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pg_reg          <= pg_next;
        upd_old_reg     <= upd_old_next;
        pend_hit_reg    <= pend_hit_next;
        pend_slot_reg   <= pend_slot_next;
        pend_ev_reg     <= pend_ev_next;
        pend_evpage_reg <= pend_evpage_next;
        out_data_reg    <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lpr_checker.sv -----
// Port-level checks for the LRU page replacement block, bound to its top level.
`default_nettype none

module lpr_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [lpr_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lpr_pkg::*;

    // A result waiting on the output stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result changed while stalled");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[4]))
        else $error("hit result reports an eviction");

    // Without an eviction the evicted page field is zero.
    a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> (m_tdata[20:5] == '0))
        else $error("evicted page nonzero without eviction");

    // Only one page reference is in progress at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

`default_nettype wire
